// ===== hw/rtl/key_value_store_defines.svh =====
// ----------------------------------------------------------------------------
// key_value_store_defines
// Assertion macros shared by the key/value store modules.
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_STORE_DEFINES_SVH
`define KEY_VALUE_STORE_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define KVS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define KVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/kvs_pkg.sv =====
// ----------------------------------------------------------------------------
// kvs_pkg
// Types and constants of the key/value store: request and response payloads,
// the token passed along the cell chain and the broadcast request bus.
// ----------------------------------------------------------------------------
package kvs_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int KEY_W   = 64;
  localparam int VAL_W   = 64;

  localparam logic [1:0] KIND_PUT    = 2'd0;
  localparam logic [1:0] KIND_GET    = 2'd1;
  localparam logic [1:0] KIND_EXISTS = 2'd2;
  localparam logic [1:0] KIND_DELETE = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [1:0]              kind;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] read_value;
  } rsp_t;

  // search token, one hop per cycle
  typedef struct packed {
    logic                    active;
    logic                    hit;
    logic                    free_found;
    logic [IDX_W-1:0]        free_idx;
    logic signed [VAL_W-1:0] rd;
  } chain_t;

  // request held by the sequencer and seen by every cell
  typedef struct packed {
    logic [1:0]              kind;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
    logic                    ins;
    logic [IDX_W-1:0]        ins_idx;
  } bus_t;

endpackage

// ===== hw/rtl/key_value_store.sv =====
// ----------------------------------------------------------------------------
// key_value_store
// Fixed-capacity associative store of 64-bit keys and signed 64-bit values,
// built as a chain of slot cells searched by a travelling token.
// ----------------------------------------------------------------------------
// Requests (put, get, exists, delete) arrive on req with req_valid/req_stall;
// one response per request leaves on rsp with rsp_valid/rsp_stall.
// A request is taken only while the block is idle. Its search token walks the
// chain one slot per cycle; the sequencer latches the token at the tail, then
// loads the response once the response register is free. A new request can be
// taken as soon as the response is valid, so one request is handled at a time.
// A put of a new key writes the lowest free slot in the cycle after the
// response is loaded, before the next search can reach it.
// The response sits in a register: while rsp_stall is high it holds, and a
// finished search waits for the register to free before completing.
// Reset empties the store at once (used flags cleared) and drops any request
// in flight; keys and values are not cleared.
// ----------------------------------------------------------------------------
module key_value_store import kvs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  chain_t links [ENTRIES+1];
  bus_t   bus;

  kvs_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .head      (links[0]),
    .tail      (links[ENTRIES]),
    .bus       (bus)
  );

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    kvs_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .slot (IDX_W'(i)),
      .bus  (bus),
      .prev (links[i]),
      .next (links[i+1])
    );
  end

endmodule

// ===== hw/rtl/kvs_cell.sv =====
// ----------------------------------------------------------------------------
// kvs_cell
// One slot of the store: key, value and used flag, plus one stage of the
// search chain that gathers hit, read value and lowest free slot.
// ----------------------------------------------------------------------------
`include "key_value_store_defines.svh"

module kvs_cell import kvs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] slot,
  input  bus_t             bus,
  input  chain_t           prev,
  output chain_t           next
);

  logic                    used;
  logic [KEY_W-1:0]        key;
  logic signed [VAL_W-1:0] value;

  logic match;
  logic insert;
  logic drop;

  assign match  = used && (key == bus.key);
  assign insert = bus.ins && (bus.ins_idx == slot);
  assign drop   = prev.active && match && (bus.kind == KIND_DELETE);

  always_ff @(posedge clk) begin
    next.hit        <= prev.hit | match;
    next.rd         <= match ? value : prev.rd;
    next.free_found <= prev.free_found | ~used;
    next.free_idx   <= (!prev.free_found && !used) ? slot : prev.free_idx;
    if (insert) begin
      key   <= bus.key;
      value <= bus.value;
    end else if (prev.active && match && bus.kind == KIND_PUT) begin
      value <= bus.value;
    end
    if (rst) begin
      used        <= 1'b0;
      next.active <= 1'b0;
    end else begin
      next.active <= prev.active;
      if (insert) begin
        used <= 1'b1;
      end else if (drop) begin
        used <= 1'b0;
      end
    end
  end

  // a key lives in one slot only
  `KVS_ASSERT_NOW(a_key_unique, prev.active && prev.hit, !match, "key held twice")
  `KVS_ASSERT_NOW(a_insert_free, insert, !used, "insert into a used slot")
  `KVS_ASSERT_NEXT(a_delete_frees, drop, !used, "delete left slot used")

endmodule

// ===== hw/rtl/kvs_seq.sv =====
// ----------------------------------------------------------------------------
// kvs_seq
// Request sequencer: takes one request, launches the search token, decides the
// outcome from the token at the chain tail and holds the response register.
// ----------------------------------------------------------------------------
`include "key_value_store_defines.svh"

module kvs_seq import kvs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   req_valid,
  output logic   req_stall,
  input  req_t   req,
  output logic   rsp_valid,
  input  logic   rsp_stall,
  output rsp_t   rsp,
  output chain_t head,
  input  chain_t tail,
  output bus_t   bus
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} state_t;

  state_t state;
  logic   head_active;
  chain_t res;
  rsp_t   rsp_next;
  logic   ins_next;
  logic   retire;

  assign req_stall = (state != S_IDLE);

  // response register free, or emptied by a transfer this cycle
  assign retire = (state == S_FIN) && (!rsp_valid || !rsp_stall);

  always_comb begin
    head        = '0;
    head.active = head_active;
  end

  always_comb begin
    rsp_next.status     = ST_OK;
    rsp_next.read_value = '0;
    ins_next            = 1'b0;
    case (bus.kind)
      KIND_PUT: begin
        if (!res.hit) begin
          if (res.free_found) begin
            ins_next = 1'b1;
          end else begin
            rsp_next.status = ST_FULL;
          end
        end
      end
      KIND_GET: begin
        if (res.hit) begin
          rsp_next.read_value = res.rd;
        end else begin
          rsp_next.status = ST_ABSENT;
        end
      end
      KIND_EXISTS, KIND_DELETE: begin
        if (!res.hit) begin
          rsp_next.status = ST_ABSENT;
        end
      end
      default: begin
        rsp_next.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head_active <= 1'b0;
      bus.ins     <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      head_active <= (state == S_IDLE) && req_valid;
      bus.ins     <= retire && ins_next;
      if (retire) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            bus.kind  <= req.kind;
            bus.key   <= req.key;
            bus.value <= req.value;
            state     <= S_RUN;
          end
        end
        S_RUN: begin
          if (tail.active) begin
            res   <= tail;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (retire) begin
            rsp         <= rsp_next;
            bus.ins_idx <= res.free_idx;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `KVS_ASSERT_NOW(a_tail_in_run, tail.active, state == S_RUN, "token out of turn")
  `KVS_ASSERT_NOW(a_ins_idle, bus.ins, state == S_IDLE, "insert during a search")
  `KVS_ASSERT_NEXT(a_launch, req_valid && !req_stall, state == S_RUN && head_active, "no launch")

endmodule

// ===== tb/tb_key_value_store.sv =====
// ----------------------------------------------------------------------------
// tb_key_value_store
// Self-checking bench for the key/value store. Requests go in over the
// req channel; a scoreboard keeps its own copy of the slot array, works out
// the response each request should give and checks responses in order.
// A short directed run covers the edge values and every request kind. Random
// phases from a shared key pool then fill the store to full, drain it and
// fill it again, with random gaps on both sides and long receiver hold-offs.
// ----------------------------------------------------------------------------
module tb_key_value_store import kvs_pkg::*; ();

  localparam int POOL_SIZE    = 96;
  localparam int IDLE_LIMIT   = 2000;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 100;

  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [KEY_W-1:0] KEY_ZERO = '0;
  localparam logic [KEY_W-1:0] KEY_ONES = '1;
  localparam logic [KEY_W-1:0] KEY_ODD  = {(KEY_W/2){2'b01}};
  localparam logic [KEY_W-1:0] KEY_EVEN = {(KEY_W/2){2'b10}};

  class kvs_scoreboard;
    logic [KEY_W-1:0]        slot_key [ENTRIES];
    logic signed [VAL_W-1:0] slot_val [ENTRIES];
    bit                      slot_used [ENTRIES];
    rsp_t                    expected_q [$];
    int                      errors;
    int                      kind_count [4];
    int                      full_count;
    int                      absent_count;
    int                      used_count;
    int                      peak_used;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      foreach (kind_count[i]) kind_count[i] = 0;
      errors       = 0;
      full_count   = 0;
      absent_count = 0;
      used_count   = 0;
      peak_used    = 0;
    endfunction

    // apply one accepted request to the slot copy and queue its response
    function void note_request(req_t r);
      int   hit;
      int   free_idx;
      rsp_t e;
      hit      = -1;
      free_idx = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_used[i] && slot_key[i] == r.key && hit < 0) hit = i;
        if (!slot_used[i] && free_idx < 0) free_idx = i;
      end
      e.status     = ST_OK;
      e.read_value = '0;
      kind_count[r.kind]++;
      case (r.kind)
        KIND_PUT: begin
          if (hit >= 0) begin
            slot_val[hit] = r.value;
          end else if (free_idx >= 0) begin
            slot_key[free_idx]  = r.key;
            slot_val[free_idx]  = r.value;
            slot_used[free_idx] = 1'b1;
            used_count++;
            if (used_count > peak_used) peak_used = used_count;
          end else begin
            e.status = ST_FULL;
          end
        end
        KIND_GET: begin
          if (hit >= 0) e.read_value = slot_val[hit];
          else e.status = ST_ABSENT;
        end
        KIND_EXISTS: begin
          if (hit < 0) e.status = ST_ABSENT;
        end
        default: begin
          if (hit >= 0) begin
            slot_used[hit] = 1'b0;
            used_count--;
          end else begin
            e.status = ST_ABSENT;
          end
        end
      endcase
      if (e.status == ST_FULL) full_count++;
      if (e.status == ST_ABSENT) absent_count++;
      expected_q.push_back(e);
    endfunction

    function void check_response(rsp_t r);
      rsp_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: response with nothing outstanding, status %0d read_value %0d",
                 $time, r.status, r.read_value);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (r.status !== e.status) begin
        $display("%0t: status mismatch, expected %0d got %0d", $time, e.status, r.status);
        errors++;
      end
      if (r.read_value !== e.read_value) begin
        $display("%0t: read_value mismatch, expected %0d got %0d",
                 $time, e.read_value, r.read_value);
        errors++;
      end
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_stall = 1'b0;
  req_t req       = '0;
  logic req_stall;
  logic rsp_valid;
  rsp_t rsp;

  kvs_scoreboard    sb;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  int               idle_cycles = 0;
  int               send_calm   = 0;
  int               recv_calm   = 0;
  int               rsp_seen    = 0;

  key_value_store u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // transfer monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) sb.check_response(rsp);
      if (req_valid && !req_stall) sb.note_request(req);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("tb_key_value_store failed");
        $finish;
      end
    end
  end

  // wait in cycles before the next transfer; now and then a run with no gaps
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  function automatic req_t build_request(logic [1:0] kind, logic [KEY_W-1:0] key,
                                         logic signed [VAL_W-1:0] value);
    req_t r;
    r.kind  = kind;
    r.key   = key;
    r.value = value;
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return VAL_MIN;
      1: return VAL_MAX;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_request(req_t item);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  task automatic run_phase(int n, int w_put, int w_get, int w_exists, int w_delete);
    int         r;
    logic [1:0] kind;
    repeat (n) begin
      r = $urandom_range(0, w_put + w_get + w_exists + w_delete - 1);
      if (r < w_put) kind = KIND_PUT;
      else if (r < w_put + w_get) kind = KIND_GET;
      else if (r < w_put + w_get + w_exists) kind = KIND_EXISTS;
      else kind = KIND_DELETE;
      send_request(build_request(kind, pick_key(), pick_value()));
    end
  endtask

  initial begin
    sb = new();
    key_pool[0] = KEY_ZERO;
    key_pool[1] = KEY_ONES;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // receiver: random hold-offs, with two long ones so the block backs up
    fork
      forever begin
        int w;
        w = draw_gap(recv_calm);
        if (rsp_seen == 300 || rsp_seen == 900) w = LONG_HOLD;
        if (w > 0) begin
          rsp_stall <= 1'b1;
          repeat (w) @(negedge clk);
        end
        rsp_stall <= 1'b0;
        do @(posedge clk); while (!rsp_valid);
        rsp_seen++;
        @(negedge clk);
      end
    join_none

    // edge keys and values, each kind, replace, absent get and delete
    send_request(build_request(KIND_PUT, KEY_ZERO, VAL_MIN));
    send_request(build_request(KIND_PUT, KEY_ONES, VAL_MAX));
    send_request(build_request(KIND_GET, KEY_ZERO, VAL_MAX));
    send_request(build_request(KIND_GET, KEY_ONES, VAL_MIN));
    send_request(build_request(KIND_EXISTS, KEY_ZERO, '0));
    send_request(build_request(KIND_EXISTS, KEY_ODD, '0));
    send_request(build_request(KIND_GET, KEY_ODD, '1));
    send_request(build_request(KIND_PUT, KEY_ZERO, -64'sd1));
    send_request(build_request(KIND_GET, KEY_ZERO, '0));
    send_request(build_request(KIND_DELETE, KEY_ONES, '0));
    send_request(build_request(KIND_DELETE, KEY_ONES, '0));
    send_request(build_request(KIND_EXISTS, KEY_ONES, '0));
    send_request(build_request(KIND_GET, KEY_ONES, '0));
    send_request(build_request(KIND_PUT, KEY_ODD, KEY_EVEN));
    send_request(build_request(KIND_PUT, KEY_EVEN, KEY_ODD));
    send_request(build_request(KIND_GET, KEY_ODD, '0));
    send_request(build_request(KIND_GET, KEY_EVEN, '0));
    send_request(build_request(KIND_DELETE, KEY_ZERO, '0));
    send_request(build_request(KIND_DELETE, KEY_ODD, '0));
    send_request(build_request(KIND_DELETE, KEY_EVEN, '0));
    send_request(build_request(KIND_EXISTS, KEY_EVEN, '0));

    // fill to full, churn, drain, refill, churn
    run_phase(250, 70, 10, 10, 10);
    run_phase(300, 30, 30, 20, 20);
    run_phase(250, 10, 20, 15, 55);
    run_phase(200, 60, 15, 15, 10);
    run_phase(250, 30, 30, 20, 20);
    req_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("requests: %0d put, %0d get, %0d exists, %0d delete",
             sb.kind_count[KIND_PUT], sb.kind_count[KIND_GET],
             sb.kind_count[KIND_EXISTS], sb.kind_count[KIND_DELETE]);
    $display("%0d full and %0d absent responses, peak occupancy %0d of %0d slots",
             sb.full_count, sb.absent_count, sb.peak_used, ENTRIES);
    if (sb.errors == 0) begin
      $display("tb_key_value_store passed");
    end else begin
      $display("tb_key_value_store failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/kvs_pkg.sv
hw/rtl/kvs_cell.sv
hw/rtl/kvs_seq.sv
hw/rtl/key_value_store.sv
tb/tb_key_value_store.sv
